// ===== rtl/image_border_sample_address_macros.svh =====
// Assertion macros used by the image border sample address top level.
`ifndef IMAGE_BORDER_SAMPLE_ADDRESS_MACROS_SVH
`define IMAGE_BORDER_SAMPLE_ADDRESS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibsa: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define IBSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibsa: next-cycle property violated");

`endif

// ===== rtl/ibsa_pkg.sv =====
// Shared constants and types of the image border sample address block.
`timescale 1ns / 1ps
`default_nettype none

package ibsa_pkg;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int CHAN_W     = 4;
    localparam int SIZE_W     = 13;
    localparam int CNT_W      = 3;
    localparam int OUTC_W     = 2;
    localparam int ADDR_W     = 26;

    // Port widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Default size limits
    localparam int DEF_MAX_WIDTH    = 4096;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int DEF_MAX_CHANNELS = 4;

    // Fold pipeline: one compare/subtract per magnitude bit below the top
    localparam int FOLD_STEPS           = COORD_W - 1;
    localparam int FOLD_STEPS_PER_STAGE = 4;
    localparam int FOLD_STAGES          =
        (FOLD_STEPS + FOLD_STEPS_PER_STAGE - 1) / FOLD_STEPS_PER_STAGE;

    // Address arithmetic stages
    localparam int ADDR_STAGES = 3;

    typedef enum logic [2:0] {
        MODE_ZERO    = 3'd0,
        MODE_NEAREST = 3'd1,
        MODE_REFLECT = 3'd2,
        MODE_NAN     = 3'd3,
        MODE_FAULT   = 3'd4
    } t_mode;

    typedef enum logic [OUTC_W-1:0] {
        OUT_READ  = 2'd0,
        OUT_ZERO  = 2'd1,
        OUT_NAN   = 2'd2,
        OUT_FAULT = 2'd3
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2,
        CFG_CHANNELS = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/ibsa_fold.sv =====
// Pipelined reflect fold of one signed coordinate into 0..size-1.
`timescale 1ns / 1ps
`default_nettype none

module ibsa_fold import ibsa_pkg::*; #(
    parameter int DIM_W = 13
) (
    input  logic                   i_clk,
    input  logic [FOLD_STAGES-1:0] i_en,
    input  logic [COORD_W-1:0]     i_coord,
    input  logic [DIM_W-1:0]       i_size,
    output logic [COORD_W-1:0]     o_coord,
    output logic [DIM_W-1:0]       o_fold
);

    localparam int PER_W = DIM_W + 1;
    localparam int CMP_W = COORD_W + DIM_W + 1;
    localparam int LAST  = FOLD_STAGES - 1;

    logic [PER_W-1:0]   period;
    logic [COORD_W-1:0] n_rem [FOLD_STAGES];
    logic [COORD_W-1:0] r_rem [FOLD_STAGES];
    logic               r_neg [FOLD_STAGES];
    logic [COORD_W-1:0] r_raw [FOLD_STAGES];

    assign period = {i_size, 1'b0};

    // Restoring reduction of |n| modulo 2p, a few shifted periods per stage
    always_comb begin
        logic [COORD_W-1:0] rem;
        int                 k;
        for (int s = 0; s < FOLD_STAGES; s++) begin
            if (s == 0) begin
                rem = i_coord[COORD_W-1] ? (~i_coord + 1'b1) : i_coord;
            end else begin
                rem = r_rem[s-1];
            end
            for (int t = 0; t < FOLD_STEPS_PER_STAGE; t++) begin
                k = FOLD_STEPS - 1 - s * FOLD_STEPS_PER_STAGE - t;
                if (k >= 0) begin
                    if (CMP_W'(rem) >= (CMP_W'(period) << k)) begin
                        rem = rem - COORD_W'(CMP_W'(period) << k);
                    end
                end
            end
            n_rem[s] = rem;
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= n_rem[0];
            r_neg[0] <= i_coord[COORD_W-1];
            r_raw[0] <= i_coord;
        end
    end

    for (genvar s = 1; s < FOLD_STAGES; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_neg[s] <= r_neg[s-1];
                r_raw[s] <= r_raw[s-1];
            end
        end
    end

    // Sign fix, then mirror the upper half of the period
    always_comb begin
        logic [PER_W-1:0] r;
        r = PER_W'(r_rem[LAST]);
        if (r_neg[LAST] && (r != '0)) begin
            r = period - r;
        end
        if (r == PER_W'(i_size)) begin
            r = r - 1'b1;
        end else if (r > PER_W'(i_size)) begin
            r = period - r;
        end
        o_fold = DIM_W'(r);
    end

    assign o_coord = r_raw[LAST];

endmodule

`default_nettype wire

// ===== rtl/ibsa_addr.sv =====
// Address arithmetic stages: (col + row*width)*channels + channel.
`timescale 1ns / 1ps
`default_nettype none

module ibsa_addr import ibsa_pkg::*; #(
    parameter int COL_W = 13,
    parameter int ROW_W = 13
) (
    input  logic                   i_clk,
    input  logic [ADDR_STAGES-1:0] i_en,
    input  logic [COL_W-1:0]       i_col,
    input  logic [ROW_W-1:0]       i_row,
    input  logic [CNT_W-1:0]       i_chan,
    input  t_outcome               i_outcome,
    input  logic [COL_W-1:0]       i_width,
    input  logic [CNT_W-1:0]       i_count,
    output t_outcome               o_outcome,
    output logic [ADDR_W-1:0]      o_addr
);

    localparam int PROD_W = COL_W + ROW_W;

    logic [PROD_W-1:0] r1_jw;
    logic [COL_W-1:0]  r1_col;
    logic [CNT_W-1:0]  r1_chan;
    t_outcome          r1_out;

    logic [ADDR_W-1:0] n_pix;
    logic [ADDR_W-1:0] r2_word;
    logic [CNT_W-1:0]  r2_chan;
    t_outcome          r2_out;

    logic [ADDR_W-1:0] r3_addr;
    t_outcome          r3_out;

    // Stage 1: row times width
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_jw   <= PROD_W'(i_row) * PROD_W'(i_width);
            r1_col  <= i_col;
            r1_chan <= i_chan;
            r1_out  <= i_outcome;
        end
    end

    // Stage 2: pixel index times channel count, modulo the address range
    assign n_pix = ADDR_W'(r1_col) + ADDR_W'(r1_jw);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_word <= n_pix * ADDR_W'(i_count);
            r2_chan <= r1_chan;
            r2_out  <= r1_out;
        end
    end

    // Stage 3: add channel, zero the address unless memory is read
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_addr <= (r2_out == OUT_READ) ? (r2_word + ADDR_W'(r2_chan)) : '0;
            r3_out  <= r2_out;
        end
    end

    assign o_outcome = r3_out;
    assign o_addr    = r3_addr;

endmodule

`default_nettype wire

// ===== rtl/image_border_sample_address.sv =====
// Path: input register, fold stages, classify register, address stages, then the master side.
// Throughput: one request per cycle while the master side accepts results; the
// fold pipeline of two lanes and the two multiplier stages each take a new item every cycle when not stalled.
// Stalls back up stage by stage, so empty stages still fill while output waits.
// Reset clears all valid bits and sets mode zero fill, sizes one; no memories.
`timescale 1ns / 1ps
`default_nettype none
`include "image_border_sample_address_macros.svh"

module image_border_sample_address import ibsa_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // column[15:0], row[31:16], channel[35:32]
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // address[25:0]
    output logic [OUTC_W-1:0]      o_m_tuser,   // outcome[1:0]
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int S_CLS = FOLD_STAGES + 1;
    localparam int NST   = S_CLS + 1 + ADDR_STAGES;
    localparam int CCW   = COORD_W + WW;
    localparam int CCH   = COORD_W + HW;

    // configuration
    t_mode             r_mode;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [CNT_W-1:0]  r_count;
    logic [WW-1:0]     w_lim;
    logic [HW-1:0]     h_lim;
    logic [CNT_W-1:0]  pd_lim;

    // pipeline control
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST-1:0] stage_en;

    // input stage
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [CHAN_W-1:0]  r_chan;
    logic [CHAN_W-1:0]  r_chan_d [FOLD_STAGES];

    // fold lane outputs
    logic [COORD_W-1:0] col_raw;
    logic [COORD_W-1:0] row_raw;
    logic [WW-1:0]      col_fold;
    logic [HW-1:0]      row_fold;

    // classify stage
    logic               col_in;
    logic               row_in;
    logic               chan_in;
    logic [WW-1:0]      col_clamp;
    logic [HW-1:0]      row_clamp;
    logic [CNT_W-1:0]   chan_clamp;
    logic [CHAN_W-1:0]  chan_raw;
    logic [WW-1:0]      n_cls_col;
    logic [HW-1:0]      n_cls_row;
    logic [CNT_W-1:0]   n_cls_chan;
    t_outcome           n_cls_out;
    logic [WW-1:0]      r_cls_col;
    logic [HW-1:0]      r_cls_row;
    logic [CNT_W-1:0]   r_cls_chan;
    t_outcome           r_cls_out;

    // address stage outputs
    t_outcome           addr_out;
    logic [ADDR_W-1:0]  addr_val;

    // Configuration register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ZERO;
            r_width  <= SIZE_W'(1);
            r_height <= SIZE_W'(1);
            r_count  <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:     r_mode   <= t_mode'(i_cfg_data[2:0]);
                CFG_WIDTH:    r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:   r_height <= i_cfg_data[SIZE_W-1:0];
                CFG_CHANNELS: r_count  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Size limits: zero reads as one, oversize reads as the maximum
    always_comb begin
        if (r_width == '0) begin
            w_lim = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else begin
            w_lim = WW'(r_width);
        end
        if (r_height == '0) begin
            h_lim = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_lim = HW'(MAX_HEIGHT);
        end else begin
            h_lim = HW'(r_height);
        end
        if (r_count == '0) begin
            pd_lim = CNT_W'(1);
        end else if (32'(r_count) > 32'(MAX_CHANNELS)) begin
            pd_lim = CNT_W'(MAX_CHANNELS);
        end else begin
            pd_lim = r_count;
        end
    end

    // Stall chain: a stage moves when it is empty or its successor moves
    always_comb begin
        stage_en[NST-1] = !r_vld[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign n_vld = {r_vld[NST-2:0], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_s_tready = stage_en[0];

    // Input register
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_col  <= i_s_tdata[15:0];
            r_row  <= i_s_tdata[31:16];
            r_chan <= i_s_tdata[35:32];
        end
    end

    // Reflect fold lanes, channel rides alongside
    ibsa_fold #(.DIM_W(WW)) u_fold_col (
        .i_clk   (i_clk),
        .i_en    (stage_en[FOLD_STAGES:1]),
        .i_coord (r_col),
        .i_size  (w_lim),
        .o_coord (col_raw),
        .o_fold  (col_fold)
    );

    ibsa_fold #(.DIM_W(HW)) u_fold_row (
        .i_clk   (i_clk),
        .i_en    (stage_en[FOLD_STAGES:1]),
        .i_coord (r_row),
        .i_size  (h_lim),
        .o_coord (row_raw),
        .o_fold  (row_fold)
    );

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_chan_d[0] <= r_chan;
        end
    end

    for (genvar s = 1; s < FOLD_STAGES; s++) begin : g_chan_dly
        always_ff @(posedge i_clk) begin
            if (stage_en[s+1]) begin
                r_chan_d[s] <= r_chan_d[s-1];
            end
        end
    end

    assign chan_raw = r_chan_d[FOLD_STAGES-1];

    // Range checks and clamps
    assign col_in  = !col_raw[COORD_W-1] &&
                     (CCW'(col_raw[COORD_W-2:0]) < CCW'(w_lim));
    assign row_in  = !row_raw[COORD_W-1] &&
                     (CCH'(row_raw[COORD_W-2:0]) < CCH'(h_lim));
    assign chan_in = !chan_raw[CHAN_W-1] &&
                     (CNT_W'(chan_raw[CHAN_W-2:0]) < pd_lim);

    assign col_clamp  = col_raw[COORD_W-1] ? '0 :
                        (col_in ? WW'(col_raw[COORD_W-2:0]) : (w_lim - 1'b1));
    assign row_clamp  = row_raw[COORD_W-1] ? '0 :
                        (row_in ? HW'(row_raw[COORD_W-2:0]) : (h_lim - 1'b1));
    assign chan_clamp = chan_raw[CHAN_W-1] ? '0 :
                        (chan_in ? CNT_W'(chan_raw[CHAN_W-2:0]) : (pd_lim - 1'b1));

    // Border mode selection
    always_comb begin
        n_cls_col  = WW'(col_raw[COORD_W-2:0]);
        n_cls_row  = HW'(row_raw[COORD_W-2:0]);
        n_cls_chan = CNT_W'(chan_raw[CHAN_W-2:0]);
        n_cls_out  = OUT_READ;
        case (r_mode)
            MODE_NEAREST: begin
                n_cls_col  = col_clamp;
                n_cls_row  = row_clamp;
                n_cls_chan = chan_clamp;
            end
            MODE_REFLECT: begin
                n_cls_col = col_fold;
                n_cls_row = row_fold;
                if (!chan_in) begin
                    n_cls_out = OUT_FAULT;
                end
            end
            default: begin
                if (!(col_in && row_in && chan_in)) begin
                    if (r_mode == MODE_ZERO) begin
                        n_cls_out = OUT_ZERO;
                    end else if (r_mode == MODE_NAN) begin
                        n_cls_out = OUT_NAN;
                    end else begin
                        n_cls_out = OUT_FAULT;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[S_CLS]) begin
            r_cls_col  <= n_cls_col;
            r_cls_row  <= n_cls_row;
            r_cls_chan <= n_cls_chan;
            r_cls_out  <= n_cls_out;
        end
    end

    // Address arithmetic
    ibsa_addr #(.COL_W(WW), .ROW_W(HW)) u_addr (
        .i_clk     (i_clk),
        .i_en      (stage_en[NST-1:S_CLS+1]),
        .i_col     (r_cls_col),
        .i_row     (r_cls_row),
        .i_chan    (r_cls_chan),
        .i_outcome (r_cls_out),
        .i_width   (w_lim),
        .i_count   (pd_lim),
        .o_outcome (addr_out),
        .o_addr    (addr_val)
    );

    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = OUT_TDATA_W'(addr_val);
    assign o_m_tuser  = addr_out;

    // Checks
    `IBSA_ASSERT_IMP(a_addr_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != OUT_READ), o_m_tdata == '0)
    `IBSA_ASSERT_IMP(a_full_when_blocked, i_clk, i_rst_n, !o_s_tready, &r_vld)
    `IBSA_ASSERT_NXT(a_accept_lands, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0])

endmodule

`default_nettype wire

// ===== dv/image_border_sample_address_test.sv =====
// Self-checking testbench for the image border sample address generator.
`timescale 1ns / 1ps

module image_border_sample_address_test;
    import ibsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int IDLE_PCT       = 38;

    typedef struct packed {
        t_outcome          outcome;
        logic [ADDR_W-1:0] addr;
    } t_sample_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;   // column[15:0], row[31:16], channel[35:32]
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // address[25:0]
    logic [OUTC_W-1:0]      o_m_tuser;        // outcome[1:0]
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Requests waiting for the driver and results waiting for the DUT
    logic [IN_TDATA_W-1:0] pending_reqs[$];
    t_sample_result        expected_results[$];

    // Register copies used for prediction
    logic [2:0]        cfg_mode   = MODE_ZERO;
    logic [SIZE_W-1:0] cfg_width  = SIZE_W'(1);
    logic [SIZE_W-1:0] cfg_height = SIZE_W'(1);
    logic [CNT_W-1:0]  cfg_chans  = CNT_W'(1);

    int  n_queued     = 0;
    int  n_accepted   = 0;
    int  n_checked    = 0;
    int  fail_count   = 0;
    int  idle_cycles  = 0;
    bit  no_idle      = 1'b0;
    bit  req_xfer     = 1'b0;

    image_border_sample_address dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Size register as the datapath uses it: zero means one, saturate at max
    function automatic int eff_size(int v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int clamp_coord(int n, int p);
        if (n < 0)
            return 0;
        if (n >= p)
            return p - 1;
        return n;
    endfunction

    // Mirror fold with period 2p; residue p maps onto p-1
    function automatic int fold_coord(int n, int p);
        int period;
        int r;
        period = 2 * p;
        r = n % period;
        if (r < 0)
            r += period;
        if (r == p)
            r -= 1;
        if (r > p)
            r = period - r;
        return r;
    endfunction

    function automatic t_sample_result predict_sample(logic [IN_TDATA_W-1:0] req);
        int             w;
        int             h;
        int             pd;
        int             col;
        int             row;
        int             chn;
        longint         lin;
        bit             outside;
        t_sample_result res;
        w   = eff_size(int'(cfg_width), DEF_MAX_WIDTH);
        h   = eff_size(int'(cfg_height), DEF_MAX_HEIGHT);
        pd  = eff_size(int'(cfg_chans), DEF_MAX_CHANNELS);
        col = int'($signed(req[15:0]));
        row = int'($signed(req[31:16]));
        chn = int'($signed(req[35:32]));
        res.outcome = OUT_READ;
        if (cfg_mode == MODE_NEAREST) begin
            col = clamp_coord(col, w);
            row = clamp_coord(row, h);
            chn = clamp_coord(chn, pd);
        end else if (cfg_mode == MODE_REFLECT) begin
            col = fold_coord(col, w);
            row = fold_coord(row, h);
            if (chn < 0 || chn >= pd)
                res.outcome = OUT_FAULT;
        end else begin
            outside = col < 0 || col >= w || row < 0 || row >= h || chn < 0 || chn >= pd;
            if (outside) begin
                if (cfg_mode == MODE_ZERO)
                    res.outcome = OUT_ZERO;
                else if (cfg_mode == MODE_NAN)
                    res.outcome = OUT_NAN;
                else
                    res.outcome = OUT_FAULT;  // fault mode and undefined modes
            end
        end
        res.addr = '0;
        if (res.outcome == OUT_READ) begin
            lin = (longint'(col) + longint'(row) * w) * pd + chn;
            res.addr = lin[ADDR_W-1:0];
        end
        return res;
    endfunction

    // Request driver: hold data until transferred, then maybe idle
    always @(negedge i_clk) begin
        logic                  nxt_valid;
        logic [IN_TDATA_W-1:0] nxt_data;
        nxt_valid = i_s_tvalid;
        nxt_data  = i_s_tdata;
        if (i_rst_n && (!i_s_tvalid || req_xfer)) begin
            nxt_valid = 1'b0;
            if (pending_reqs.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                nxt_data  = pending_reqs.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_s_tvalid <= nxt_valid;
        i_s_tdata  <= nxt_data;
    end

    // Result sink backpressure
    always @(negedge i_clk) begin
        i_m_tready <= i_rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on request transfers, check result transfers
    always @(posedge i_clk) begin
        t_sample_result exp_res;
        bit             any_xfer;
        req_xfer <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            any_xfer = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                any_xfer = 1'b1;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:     cfg_mode   = i_cfg_data[2:0];
                    CFG_WIDTH:    cfg_width  = i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:   cfg_height = i_cfg_data[SIZE_W-1:0];
                    CFG_CHANNELS: cfg_chans  = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                any_xfer = 1'b1;
                expected_results.push_back(predict_sample(i_s_tdata));
                n_accepted++;
            end
            if (o_m_tvalid && i_m_tready) begin
                any_xfer = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result outcome %0d address %0h",
                             $time, o_m_tuser, o_m_tdata);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    n_checked++;
                    if (o_m_tuser !== exp_res.outcome) begin
                        $display("%0t: outcome mismatch expected %0d actual %0d",
                                 $time, exp_res.outcome, o_m_tuser);
                        fail_count++;
                    end
                    if (o_m_tdata !== OUT_TDATA_W'(exp_res.addr)) begin
                        $display("%0t: address mismatch expected %0h actual %0h",
                                 $time, exp_res.addr, o_m_tdata);
                        fail_count++;
                    end
                end
            end
            idle_cycles = any_xfer ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("image_border_sample_address test failed");
        $finish;
    end

    task automatic push_req(int col, int row, int chn);
        logic [IN_TDATA_W-1:0] req;
        req = '0;
        req[15:0]  = col[15:0];
        req[31:16] = row[15:0];
        req[35:32] = chn[3:0];
        pending_reqs.push_back(req);
        n_queued++;
    endtask

    // Wait at a falling edge until every queued request has its result back
    task automatic wait_drained();
        @(negedge i_clk);
        while (n_accepted != n_queued || n_checked != n_accepted)
            @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    // Block must be idle; writes all four registers back to back
    task automatic set_config(logic [CFG_DATA_W-1:0] mode, logic [CFG_DATA_W-1:0] w,
                              logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] c);
        cfg_write(CFG_MODE, mode);
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_CHANNELS, c);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Coordinate mostly around the image, sometimes anywhere
    function automatic int pick_coord(int p);
        if ($urandom_range(99) < 70)
            return int'($urandom_range(0, 4 * p + 3)) - (p + 1);
        return int'($signed(16'($urandom)));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 5)
            return CFG_DATA_W'($urandom_range(1, 9));
        if (sel == 6)
            return '0;
        if (sel == 7)
            return CFG_DATA_W'(4096);
        if (sel == 8)
            return '1;
        return CFG_DATA_W'($urandom);
    endfunction

    // Main sequence
    initial begin
        int                    n_items;
        int                    m;
        int                    wp;
        int                    hp;
        logic [CFG_DATA_W-1:0] mode_d;
        logic [CFG_DATA_W-1:0] w_d;
        logic [CFG_DATA_W-1:0] h_d;
        logic [CFG_DATA_W-1:0] c_d;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: zero fill on a 1x1 single-channel image
        push_req(0, 0, 0);
        push_req(1, 0, 0);
        push_req(0, -1, 0);
        push_req(0, 0, -8);
        wait_drained();

        // Nearest clamp on the largest image, extreme coordinates
        set_config(MODE_NEAREST, 4096, 4096, 4);
        push_req(32767, 32767, 7);
        push_req(-32768, -32768, -8);
        push_req(100, -5, 2);
        wait_drained();

        // Reflect, junk above the mode bits; edges of the fold and channel fault
        set_config(13'h1FF8 | MODE_REFLECT, 4, 3, 2);
        push_req(4, 3, 0);
        push_req(5, 5, 1);
        push_req(8, 6, 0);
        push_req(-1, -1, 0);
        push_req(-4, -7, 1);
        push_req(32767, -32768, 0);
        push_req(1, 1, 2);
        push_req(1, 1, -1);
        wait_drained();

        // NaN fill with zero sizes and an oversize height
        set_config(MODE_NAN, 0, 8191, 0);
        push_req(0, 4095, 0);
        push_req(0, 4096, 0);
        push_req(-1, 0, 0);
        wait_drained();

        // Fault mode with oversize channel count
        set_config(MODE_FAULT, 2, 2, 7);
        push_req(1, 1, 3);
        push_req(2, 0, 0);
        wait_drained();

        // Undefined mode acts as fault
        set_config(7, 3, 3, 1);
        push_req(1, 1, 0);
        push_req(5, 0, 0);
        wait_drained();

        // Random phases; each one drains fully before the next setting
        for (int ph = 0; ph < 16; ph++) begin
            m = $urandom_range(9);
            mode_d = (m > 7) ? CFG_DATA_W'(MODE_REFLECT) : CFG_DATA_W'(m);
            mode_d[CFG_DATA_W-1:3] = (CFG_DATA_W-3)'($urandom);
            w_d = pick_size();
            h_d = pick_size();
            c_d = CFG_DATA_W'($urandom_range(0, 7));
            c_d[CFG_DATA_W-1:3] = (CFG_DATA_W-3)'($urandom);
            set_config(mode_d, w_d, h_d, c_d);
            wp = eff_size(int'(w_d), DEF_MAX_WIDTH);
            hp = eff_size(int'(h_d), DEF_MAX_HEIGHT);
            no_idle = (ph == 4);
            n_items = (ph == 4) ? 100 : 47;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(99) < 80)
                    push_req(pick_coord(wp), pick_coord(hp), int'($urandom_range(0, 6)) - 1);
                else
                    push_req(pick_coord(wp), pick_coord(hp), int'($signed(4'($urandom))));
            end
            wait_drained();
            no_idle = 1'b0;
        end

        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("image_border_sample_address test passed");
        else
            $display("image_border_sample_address test failed");
        $finish;
    end

endmodule
